// ===== rtl/gle_pkg.sv =====
// Shared types and constants for the GIF LZW encoder.
`default_nettype none

package gle_pkg;

  // Widest code the stream can carry, and the width of a code length field.
  localparam int CODE_W = 12;
  localparam int LEN_W  = 4;

  // Configuration port: byte address bits and register index of min_code_size.
  localparam int         CFG_AW            = 3;
  localparam logic [0:0] REG_MIN_CODE_SIZE = 1'b0;
  localparam logic [3:0] MIN_CODE_SIZE_RST = 4'd8;

  // Codes one pixel can queue: lead code, table-full clear, three flush codes.
  localparam int NUM_SLOTS = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DICT,
    ST_DECIDE
  } seq_state_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
  } code_item_t;

endpackage

`default_nettype wire

// ===== rtl/gif_lzw_encoder_top.sv =====
// Top level of the GIF LZW encoder: register port, lookup core and bit packer.
//
// Usage
//   Pixels (palette indexes) enter on in_valid/in_ready with in_last_pixel
//   marking the final pixel of a frame. The packed LZW stream leaves one byte
//   per item on out_valid/out_ready, codes LSB first; out_last_byte flags the
//   zero-padded final byte of each frame. min_code_size (address 0) is taken
//   at the first pixel of every frame; write it only while no pixel is in flight.
//   Pixel flow: each pixel does a forward-table read and then a reverse-table
//   read before the new prefix is known; the next pixel's lookup is issued in
//   the decision cycle, so a new pixel is taken as the previous one is decided.
//   A pixel that queues several codes (frame start, table full, flush) holds
//   the next decision until its queue drains, one code per cycle while the
//   packer takes them; the stream side moves at most one byte per cycle.
//   Path: forward read, reverse read, decision, code queue, packer, byte out.
//   Reset: control state clears at once; the dictionary needs no clearing
//   pass, as an entry only counts when its code was handed out since the last
//   clear and the reverse table points back at that slot.
//   Stall: while out_ready is low the output byte holds, the packer fills to
//   24 bits, then the code queue and finally in_ready back up.
`default_nettype none

module gif_lzw_encoder_top import gle_pkg::*; #(
  parameter int CODE_SPACE      = 4096,
  parameter int MAX_SYMBOL_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // pixels in
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_pixel_index,
  input  wire logic              in_last_pixel,
  // bytes out
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last_byte
);

  logic [3:0] min_code_size_r;
  logic       cfg_wr;
  logic [0:0] reg_sel;

  logic       code_valid, code_ready;
  code_item_t code_item;

  // Register index sits above the byte offset.
  assign reg_sel = paddr[CFG_AW-1:CFG_AW-1];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == REG_MIN_CODE_SIZE) ? 32'(min_code_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_code_size_r <= MIN_CODE_SIZE_RST;
    end else if (cfg_wr && (reg_sel == REG_MIN_CODE_SIZE)) begin
      min_code_size_r <= pwdata[3:0];
    end
  end

  gle_core #(
    .CODE_SPACE      (CODE_SPACE),
    .MAX_SYMBOL_BITS (MAX_SYMBOL_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .min_code_size  (min_code_size_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_index (in_pixel_index),
    .in_last_pixel  (in_last_pixel),
    .code_valid     (code_valid),
    .code_item      (code_item),
    .code_ready     (code_ready)
  );

  gle_packer u_packer (
    .clk           (clk),
    .rst_n         (rst_n),
    .code_valid    (code_valid),
    .code_item     (code_item),
    .code_ready    (code_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

`default_nettype wire

// ===== rtl/gle_core.sv =====
// Dictionary lookup, code assignment and per-pixel code queue.
`default_nettype none

module gle_core import gle_pkg::*; #(
  parameter int CODE_SPACE      = 4096,
  parameter int MAX_SYMBOL_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [3:0] min_code_size,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_pixel_index,
  input  wire logic       in_last_pixel,
  output logic            code_valid,
  output code_item_t      code_item,
  input  wire logic       code_ready
);

  localparam int CB    = $clog2(CODE_SPACE);
  localparam int SB    = MAX_SYMBOL_BITS;
  localparam int AW    = CB + SB;
  localparam int DEPTH = 1 << AW;
  localparam int CODES = 1 << CB;
  localparam int SEL_W = $clog2(NUM_SLOTS);

  localparam logic [3:0]           SB_4      = 4'(SB);
  localparam logic [3:0]           FMIN_RST  = (MIN_CODE_SIZE_RST > SB_4) ? SB_4
                                                                           : MIN_CODE_SIZE_RST;
  localparam logic [CB-1:0]        LAST_CODE = CB'(CODE_SPACE - 1);
  localparam logic [NUM_SLOTS-1:0] V_ONE     = NUM_SLOTS'(1);

  // Queue slots, in stream order.
  localparam int SLOT_LEAD   = 0;
  localparam int SLOT_FULL   = 1;
  localparam int SLOT_FLUSH  = 2;
  localparam int SLOT_FCLEAR = 3;
  localparam int SLOT_END    = 4;

  function automatic logic [3:0] clamp_min(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v < 4'd2) r = 4'd2;
    else if (v > SB_4) r = SB_4;
    return r;
  endfunction

  function automatic logic [SB-1:0] sym_mask(input logic [3:0] fmin);
    logic [CB-1:0] c;
    c = CB'(1) << fmin;
    return SB'(c) - SB'(1);
  endfunction

  // Memories: forward table (slot -> code) and reverse table (code -> slot).
  logic [CB-1:0] dict_mem [DEPTH];
  logic [AW-1:0] rev_mem  [CODES];

  seq_state_t state_r, state_nxt;

  logic [SB-1:0] pix_r;
  logic          last_r;
  logic [AW-1:0] slot_r;
  logic [CB-1:0] dict_q_r;
  logic [AW-1:0] rev_q_r;

  logic          frame_open_r;
  logic [3:0]    fmin_r;
  logic [CB-1:0] prefix_r;
  logic          pv_r;
  logic [CB-1:0] nfc_r;
  logic [3:0]    cw_r;

  code_item_t           list_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] list_v_r;

  logic             accept, decide, list_drained, pop, rev_rd, wr_en, wr_en_q, hit;
  logic [SEL_W-1:0] pop_sel;
  logic [AW-1:0]    rd_addr;

  // Decision terms
  logic                 fo, pv0, fo_fin, pv_fin;
  logic [3:0]           fmin_d, cw0, cw_fin;
  logic [CB-1:0]        clear_d, nfc0, nfc_inc, nfc_fin, prefix_fin, sym_ext;
  logic [SB-1:0]        sym_d;
  code_item_t           items [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] items_v;

  // Queue drain: lowest slot first
  always_comb begin
    pop_sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (list_v_r[i]) pop_sel = SEL_W'(i);
    end
  end

  assign code_valid   = |list_v_r;
  assign code_item    = list_r[pop_sel];
  assign pop          = code_valid && code_ready;
  assign list_drained = (list_v_r == '0) ||
                        (((list_v_r & (list_v_r - V_ONE)) == '0) && pop);
  assign decide       = (state_r == ST_DECIDE) && list_drained;
  assign accept       = in_valid && in_ready;
  assign wr_en_q      = decide && wr_en;

  // Per-pixel decision
  always_comb begin
    fo      = frame_open_r;
    fmin_d  = fo ? fmin_r : clamp_min(min_code_size);
    clear_d = CB'(1) << fmin_d;
    cw0     = fo ? cw_r : fmin_d + 4'd1;
    nfc0    = fo ? nfc_r : clear_d + CB'(1);
    pv0     = fo ? pv_r : 1'b0;
    sym_d   = pix_r & sym_mask(fmin_d);
    sym_ext = CB'(sym_d);

    // Entry is live only if its code was handed out since the last table clear.
    hit = 1'b0;
    if ((dict_q_r >= clear_d + CB'(2)) && (dict_q_r <= nfc_r) && (rev_q_r == slot_r)) begin
      hit = 1'b1;
    end

    for (int i = 0; i < NUM_SLOTS; i++) items[i] = '0;
    items_v    = '0;
    wr_en      = 1'b0;
    nfc_inc    = nfc0 + CB'(1);
    nfc_fin    = nfc0;
    cw_fin     = cw0;
    prefix_fin = prefix_r;
    fo_fin     = 1'b1;
    pv_fin     = 1'b1;

    if (!fo) begin
      items[SLOT_LEAD]   = '{code: CODE_W'(clear_d), len: cw0, last: 1'b0};
      items_v[SLOT_LEAD] = 1'b1;
    end

    if (!pv0) begin
      prefix_fin = sym_ext;
    end else if (hit) begin
      prefix_fin = dict_q_r;
    end else begin
      items[SLOT_LEAD]   = '{code: CODE_W'(prefix_r), len: cw0, last: 1'b0};
      items_v[SLOT_LEAD] = 1'b1;
      wr_en              = 1'b1;
      nfc_fin            = nfc_inc;
      // early change
      if ({1'b0, nfc_inc} == ((CB+1)'(1) << cw0)) cw_fin = cw0 + 4'd1;
      if (nfc_inc == LAST_CODE) begin
        items[SLOT_FULL]   = '{code: CODE_W'(clear_d), len: cw_fin, last: 1'b0};
        items_v[SLOT_FULL] = 1'b1;
        cw_fin             = fmin_d + 4'd1;
        nfc_fin            = clear_d + CB'(1);
      end
      prefix_fin = sym_ext;
    end

    if (last_r) begin
      items[SLOT_FLUSH]    = '{code: CODE_W'(prefix_fin), len: cw_fin, last: 1'b0};
      items[SLOT_FCLEAR]   = '{code: CODE_W'(clear_d), len: cw_fin, last: 1'b0};
      items[SLOT_END]      = '{code: CODE_W'(clear_d + CB'(1)), len: fmin_d + 4'd1,
                               last: 1'b1};
      items_v[SLOT_FLUSH]  = 1'b1;
      items_v[SLOT_FCLEAR] = 1'b1;
      items_v[SLOT_END]    = 1'b1;
      fo_fin               = 1'b0;
      pv_fin               = 1'b0;
      prefix_fin           = '0;
    end
  end

  // Lookup address of the incoming pixel uses the prefix as it stands after this edge.
  always_comb begin
    if (decide) begin
      rd_addr = {prefix_fin, in_pixel_index[SB-1:0] & sym_mask(fmin_d)};
    end else begin
      rd_addr = {prefix_r, in_pixel_index[SB-1:0] & sym_mask(fmin_r)};
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DICT;
      end
      ST_DICT: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (decide) state_nxt = accept ? ST_DICT : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    rev_rd   = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_DICT:   rev_rd   = 1'b1;
      ST_DECIDE: in_ready = decide;
      default: begin
        in_ready = 1'b0;
        rev_rd   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      frame_open_r <= 1'b0;
      fmin_r       <= FMIN_RST;
      prefix_r     <= '0;
      pv_r         <= 1'b0;
      nfc_r        <= (CB'(1) << FMIN_RST) + CB'(1);
      cw_r         <= FMIN_RST + 4'd1;
      list_v_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (decide) begin
        frame_open_r <= fo_fin;
        fmin_r       <= fmin_d;
        prefix_r     <= prefix_fin;
        pv_r         <= pv_fin;
        nfc_r        <= nfc_fin;
        cw_r         <= cw_fin;
        list_v_r     <= items_v;
      end else if (pop) begin
        list_v_r[pop_sel] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (decide) list_r <= items;
    if (accept) begin
      pix_r  <= in_pixel_index[SB-1:0];
      last_r <= in_last_pixel;
      slot_r <= rd_addr;
    end
  end

  // Forward table; a read of the slot written at the same edge sees the new code.
  always_ff @(posedge clk) begin
    if (wr_en_q) dict_mem[slot_r] <= nfc_inc;
    if (accept) begin
      if (wr_en_q && (slot_r == rd_addr)) dict_q_r <= nfc_inc;
      else dict_q_r <= dict_mem[rd_addr];
    end
  end

  // Reverse table; never read and written at the same edge.
  always_ff @(posedge clk) begin
    if (wr_en_q) rev_mem[nfc_inc] <= slot_r;
    if (rev_rd) rev_q_r <= rev_mem[dict_q_r];
  end

`ifndef SYNTHESIS
  a_width_covers: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r |-> ({1'b0, nfc_r} < ((CB+1)'(1) << cw_r)))
    else $error("next free code outside current code width");

  a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en_q |-> (frame_open_r && pv_r && !hit))
    else $error("table write without an open prefix");

  a_flush_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (decide && last_r) |=> (list_v_r[SLOT_END] && !frame_open_r && !pv_r))
    else $error("last pixel did not queue the end code");
`endif

endmodule

`default_nettype wire

// ===== rtl/gle_packer.sv =====
// Bit packer: variable-width codes in, LSB-first bytes out.
`default_nettype none

module gle_packer import gle_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       code_valid,
  input  wire code_item_t code_item,
  output logic            code_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_byte
);

  localparam int ACC_W = 2 * CODE_W;
  localparam int CNT_W = $clog2(ACC_W + 1);

  localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(8);

  logic [ACC_W-1:0] acc_r, acc_nxt, acc_sh, bits;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_sh;
  logic             fin_r, fin_nxt;
  logic             out_valid_r, out_last_r;
  logic [7:0]       out_byte_r;
  logic             slot_free, emit, emit_last, absorb;

  always_comb begin
    slot_free = !out_valid_r || out_ready;
    emit      = slot_free && ((cnt_r >= BYTE_BITS) || (fin_r && (cnt_r != '0)));
    emit_last = fin_r && (cnt_r <= BYTE_BITS);
    acc_sh    = emit ? (acc_r >> 8) : acc_r;
    cnt_sh    = cnt_r;
    if (emit) cnt_sh = (cnt_r > BYTE_BITS) ? cnt_r - BYTE_BITS : '0;

    // Hold back the next frame until the padded final byte is out.
    code_ready = !fin_r &&
                 (((CNT_W+1)'(cnt_sh) + (CNT_W+1)'(code_item.len)) <= (CNT_W+1)'(ACC_W));
    absorb     = code_valid && code_ready;

    bits    = (ACC_W'(code_item.code) & ~({ACC_W{1'b1}} << code_item.len)) << cnt_sh;
    acc_nxt = absorb ? (acc_sh | bits) : acc_sh;
    cnt_nxt = absorb ? cnt_sh + CNT_W'(code_item.len) : cnt_sh;

    fin_nxt = fin_r;
    if (emit && emit_last) fin_nxt = 1'b0;
    if (absorb && code_item.last) fin_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= acc_r[7:0];
      out_last_r <= emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

`ifndef SYNTHESIS
  a_pad_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> ((cnt_r == '0) && (acc_r == '0)))
    else $error("bits left after the final byte");

  a_fin_set: assert property (@(posedge clk) disable iff (!rst_n)
    (absorb && code_item.last) |=> (fin_r && (cnt_r != '0)))
    else $error("end code taken without pending flush");

  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(ACC_W)) && ((acc_r >> cnt_r) == '0))
    else $error("accumulator holds bits above its fill");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the GIF LZW encoder top level.
`timescale 1ns / 100ps

module tb;
  import gle_pkg::*;

  // Matches the block's default sizing.
  localparam int CODE_SPACE  = 4096;
  localparam int SYM_BITS    = 8;
  // Quiet cycles allowed after the last expected byte (pixels that hit the
  // table produce nothing, so the block may still be busy at that point).
  localparam int SETTLE_CYC  = 24;
  localparam int FILL_PIXELS = 48;
  localparam logic [CFG_AW-1:0] MCS_ADDR = CFG_AW'(4 * REG_MIN_CODE_SIZE);

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // One pixel waiting for the driver.
  typedef struct {
    logic [7:0] index;
    logic       fin;
  } pixel_item_t;

  // One byte of the code stream as the encoder should send it.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_pixel_index = '0;
  logic       in_last_pixel = 1'b0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_byte;

  gif_lzw_encoder_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_index(in_pixel_index),
    .in_last_pixel (in_last_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bookkeeping
  // --------------------------------------------------------------------------
  pixel_item_t  pixel_q[$];     // pixels not yet handed to the driver
  stream_byte_t byte_q[$];      // bytes the encoder still owes us
  int errors        = 0;
  int pixels_in     = 0;
  int bytes_checked = 0;
  int frames_done   = 0;
  int table_resets  = 0;
  logic [8:0] widths_seen = '0; // effective min_code_size values framed

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic in_taken = 1'b0;        // the item on the input port went in last edge

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40)
      $display("ERROR @%0t: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Encoder model state: register copy, per-frame width, string table and the
  // LSB-first bit packer.
  // --------------------------------------------------------------------------
  logic [3:0]  mcs_reg = MIN_CODE_SIZE_RST;
  int          frame_bits;
  int          prefix;
  logic        prefix_ok = 1'b0;
  int          next_code;
  int          code_len;
  logic [7:0]  acc = '0;
  int          acc_n = 0;
  logic        open_frame = 1'b0;
  logic [11:0] code_table[int]; // absent entry == no string yet

  function automatic int clamp_bits(input logic [3:0] v);
    if (v < 2) return 2;
    if (v > SYM_BITS) return SYM_BITS;
    return int'(v);
  endfunction

  task automatic restart_table();
    code_table.delete();
    code_len  = frame_bits + 1;
    next_code = (1 << frame_bits) + 1;
  endtask

  task automatic pack_code(input int code, input int len);
    stream_byte_t b;
    for (int i = 0; i < len; i++) begin
      acc[acc_n] = (code >> i) & 1;
      acc_n++;
      if (acc_n == 8) begin
        b.data = acc;
        b.last = 1'b0;
        byte_q.push_back(b);
        acc   = '0;
        acc_n = 0;
      end
    end
  endtask

  // Runs one accepted pixel through the encoder model, queuing its bytes.
  task automatic encode_pixel(input logic [7:0] pix, input logic fin);
    int clr, sym, slot, n0;
    stream_byte_t tail;
    n0 = byte_q.size();
    if (!open_frame) begin
      frame_bits = clamp_bits(mcs_reg);
      widths_seen[frame_bits] = 1'b1;
      restart_table();
      prefix_ok  = 1'b0;
      acc        = '0;
      acc_n      = 0;
      open_frame = 1'b1;
      pack_code(1 << frame_bits, code_len);
    end
    clr = 1 << frame_bits;
    sym = int'(pix) & (clr - 1);

    if (!prefix_ok) begin
      prefix    = sym;
      prefix_ok = 1'b1;
    end else begin
      slot = (prefix << SYM_BITS) | sym;
      if (code_table.exists(slot)) begin
        prefix = int'(code_table[slot]);
      end else begin
        pack_code(prefix, code_len);
        next_code++;
        code_table[slot] = 12'(next_code);
        // early change
        if (next_code >= (1 << code_len))
          code_len++;
        // table full: clear goes out in the grown width
        if (next_code == CODE_SPACE - 1) begin
          pack_code(clr, code_len);
          restart_table();
          table_resets++;
        end
        prefix = sym;
      end
    end

    if (fin) begin
      pack_code(prefix, code_len);
      pack_code(clr, code_len);
      pack_code(clr + 1, frame_bits + 1);
      while (acc_n != 0)
        pack_code(0, 1);
      if (byte_q.size() > n0) begin
        tail = byte_q.pop_back();
        tail.last = 1'b1;
        byte_q.push_back(tail);
      end
      open_frame = 1'b0;
      prefix_ok  = 1'b0;
      prefix     = 0;
      frames_done++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued pixels at the falling edge, with random gaps.
  // Receiver ready toggles on the same edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    pixel_item_t it;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pixel_q.pop_front();
        in_valid       <= 1'b1;
        in_pixel_index <= it.index;
        in_last_pixel  <= it.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each accepted pixel, checks each accepted byte.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        encode_pixel(in_pixel_index, in_last_pixel);
        pixels_in++;
      end
      if (out_valid && out_ready) begin
        if (byte_q.size() == 0) begin
          report_mismatch($sformatf("byte 0x%02h with nothing expected", out_byte));
        end else begin
          want = byte_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("byte %0d: out_byte 0x%02h, want 0x%02h",
                                      bytes_checked, out_byte, want.data));
          if (out_last_byte !== want.last)
            report_mismatch($sformatf("byte %0d: out_last_byte %b, want %b",
                                      bytes_checked, out_last_byte, want.last));
          bytes_checked++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_pixel(input logic [7:0] index, input logic fin);
    pixel_item_t it;
    it.index = index;
    it.fin   = fin;
    pixel_q.push_back(it);
  endtask

  task automatic set_idle(input idle_mode_t m);
    send_idle_pct  = (m == IDLE_SEND) ? 61 : (m == IDLE_BOTH) ? 9 : 0;
    recv_stall_pct = (m == IDLE_RECV) ? 61 : (m == IDLE_BOTH) ? 9 : 0;
  endtask

  // Block until all pixels are in, all bytes are out, and the core has had
  // time to finish any pixel that produced no byte.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || byte_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // APB write of min_code_size with junk in the unused bits, then read back.
  task automatic write_min_code_size(input logic [3:0] value);
    logic [31:0] w;
    w = $urandom();
    w[3:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MCS_ADDR;
    pwdata  <= w;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mcs_reg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[3:0] !== value)
      report_mismatch($sformatf("min_code_size reads 0x%0h, wrote 0x%0h",
                                prdata[3:0], value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Half the time a small alphabet so strings grow long, plus in-range and
  // out-of-range noise.
  function automatic logic [7:0] pick_pixel(input int bits);
    case ($urandom_range(3))
      0:       return 8'($urandom_range(255));
      1:       return 8'($urandom_range((1 << bits) - 1));
      default: return 8'($urandom_range(2));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int cfg_values[8];
    int bits, n, flen;
    logic [3:0] val;

    set_idle(IDLE_NONE);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset width of 8 first, no register write yet.
    push_pixel(8'd0, 1'b1);                      // single-pixel frame
    repeat (5) push_pixel(8'd255, 1'b0);         // repeated pixel, table hits
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd1, 1'b0);                      // frame left open ...
    push_pixel(8'd2, 1'b0);
    push_pixel(8'd1, 1'b0);
    push_pixel(8'd2, 1'b0);
    wait_idle();
    write_min_code_size(4'd2);                   // ... written mid-frame
    push_pixel(8'd1, 1'b0);                      // still 8-bit symbols here
    push_pixel(8'd2, 1'b0);
    push_pixel(8'd3, 1'b1);
    push_pixel(8'd255, 1'b0);                    // 2-bit frame, index masked
    push_pixel(8'd3, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd7, 1'b1);
    wait_idle();
    write_min_code_size(4'd0);                   // below range, acts as 2
    push_pixel(8'd5, 1'b1);
    wait_idle();
    write_min_code_size(4'd15);                  // above range, acts as 8
    push_pixel(8'd128, 1'b0);
    push_pixel(8'd127, 1'b1);
    wait_idle();
    write_min_code_size(4'd3);                   // 4+4+4+4 bits: no pad byte
    push_pixel(8'd6, 1'b1);
    wait_idle();

    // One longer 8-bit frame, mixing table hits and misses.
    write_min_code_size(4'd8);
    for (int i = 0; i < FILL_PIXELS; i++)
      push_pixel(pick_pixel(8), i == FILL_PIXELS - 1);
    wait_idle();

    // Random phases: a setting per phase, idle mode cycling, short frames.
    cfg_values = '{2, 8, 1, 9, 5, 15, 0, 4};
    cfg_values[7] = $urandom_range(15);
    for (int p = 0; p < 8; p++) begin
      set_idle(idle_mode_t'(p % 4));
      val = 4'(cfg_values[p]);
      write_min_code_size(val);
      bits = clamp_bits(val);
      n = 0;
      while (n < 12) begin
        flen = ($urandom_range(4) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
        for (int i = 0; i < flen; i++)
          push_pixel(pick_pixel(bits), i == flen - 1);
        n += flen;
      end
      wait_idle();
    end

    if (byte_q.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", byte_q.size()));
    $display("Encoded %0d pixels in %0d frames, %0d bytes checked, %0d table restarts.",
             pixels_in, frames_done, bytes_checked, table_resets);
    $display("Symbol widths framed (bit n = n bits): %b; mismatches: %0d.",
             widths_seen, errors);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gle_pkg.sv
rtl/gle_core.sv
rtl/gle_packer.sv
rtl/gif_lzw_encoder_top.sv
test/tb.sv
